// ----- sv/assert_macros.svh -----
// Assertion macros for the seven-segment scanner RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/cssc_pkg.sv -----
// Shared types and constants of the chained seven-segment scanner.
// No dependencies; imported by cssc_core and the top level.
`default_nettype none
package cssc_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SCAN  = 2'd0;
  localparam mode_t MODE_BLANK = 2'd1;
  localparam mode_t MODE_CMD   = 2'd2;

  localparam logic [3:0]  CHECK_NIBBLE = 4'hA;
  localparam logic [3:0]  ADDR_RESET   = 4'h4;
  localparam logic [31:0] FORWARD_STEP = 32'h0001_0000;
  localparam logic [3:0]  COMMONS_OFF  = 4'hF;

  typedef struct packed {
    logic [6:0]  segments;
    logic [3:0]  commons;
    logic        forward_valid;
    logic [31:0] forward_word;
  } result_t;

  function automatic logic [6:0] hex_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'h0: p = 7'h3F;
      4'h1: p = 7'h06;
      4'h2: p = 7'h5B;
      4'h3: p = 7'h4F;
      4'h4: p = 7'h66;
      4'h5: p = 7'h6D;
      4'h6: p = 7'h7D;
      4'h7: p = 7'h07;
      4'h8: p = 7'h7F;
      4'h9: p = 7'h6F;
      4'hA: p = 7'h77;
      4'hB: p = 7'h7C;
      4'hC: p = 7'h39;
      4'hD: p = 7'h5E;
      4'hE: p = 7'h79;
      default: p = 7'h71;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cssc_core.sv -----
// Display state (digit store, scan position, drives) and the per-request step logic.
// Depends on cssc_pkg.
`default_nettype none
module cssc_core import cssc_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire mode_t       mode,
  input  wire logic [31:0] command_word,
  input  wire logic [3:0]  own_address,
  output result_t          res
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int LOAD_N = (DIGIT_COUNT < 4) ? DIGIT_COUNT : 4;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

  logic [3:0]       digits_r   [DIGIT_COUNT];
  logic [3:0]       digits_nxt [DIGIT_COUNT];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [6:0]       seg_r, seg_nxt;
  logic [3:0]       com_r, com_nxt;
  logic [2:0]       pos_ext;
  logic             own_hit;

  assign pos_ext = 3'(pos_r);
  assign own_hit = (command_word[19:16] == own_address);

  always_comb begin
    digits_nxt = digits_r;
    pos_nxt    = pos_r;
    seg_nxt    = seg_r;
    com_nxt    = com_r;
    res.forward_valid = 1'b0;
    res.forward_word  = '0;
    case (mode)
      MODE_SCAN: begin
        for (int k = 0; k < 4; k++) begin
          com_nxt[k] = !((k < DIGIT_COUNT) && (pos_ext == 3'(k)));
        end
        seg_nxt = hex_pattern(digits_r[pos_r]);
        pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
      end
      MODE_BLANK: begin
        com_nxt = COMMONS_OFF;
      end
      MODE_CMD: begin
        if (own_hit) begin
          if (command_word[23:20] == CHECK_NIBBLE) begin
            for (int i = 0; i < LOAD_N; i++) begin
              digits_nxt[i] = command_word[15 - 4*i -: 4];
            end
          end
        end else if (command_word != '0) begin
          res.forward_valid = 1'b1;
          res.forward_word  = command_word - FORWARD_STEP;
        end
      end
      default: begin
      end
    endcase
    res.segments = seg_nxt;
    res.commons  = com_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits_r[i] <= 4'(i);
      end
      pos_r <= '0;
      seg_r <= '0;
      com_r <= COMMONS_OFF;
    end else if (step) begin
      digits_r <= digits_nxt;
      pos_r    <= pos_nxt;
      seg_r    <= seg_nxt;
      com_r    <= com_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/chained_seven_segment_scanner.sv -----
// Multiplexed hex seven-segment driver on a command daisy chain. Each request
// (scan tick, blank tick or command word) is captured in an input register,
// processed combinationally by cssc_core and its result held in an output
// register; one request per cycle is sustained, and out_valid is driven from
// the output register. Both registers stall only on out_ready low.
// Depends on cssc_pkg, cssc_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module chained_seven_segment_scanner import cssc_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_command_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_segments,
  output logic [3:0]       out_commons,
  output logic             out_forward_valid,
  output logic [31:0]      out_forward_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic [31:0] s1_word_r;
  logic        s1_go;
  logic        out_valid_r;
  result_t     res, res_r;
  logic [3:0]  own_addr_r;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      own_addr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r <= in_mode;
      s1_word_r <= in_command_word;
    end
  end

  cssc_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_go),
    .mode         (s1_mode_r),
    .command_word (s1_word_r),
    .own_address  (own_addr_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segments      = res_r.segments;
  assign out_commons       = res_r.commons;
  assign out_forward_valid = res_r.forward_valid;
  assign out_forward_word  = res_r.forward_word;

  `CSSC_ASSERT_IMP(a_one_digit_on, clk, rst_n, out_valid, $onehot0(~out_commons))
  `CSSC_ASSERT_IMP(a_fwd_zero, clk, rst_n, out_valid && !out_forward_valid, out_forward_word == '0)
  `CSSC_ASSERT_NXT(a_s1_held, clk, rst_n, s1_valid_r && !s1_go, s1_valid_r && $stable(s1_word_r))
  `CSSC_ASSERT_NXT(a_out_loaded, clk, rst_n, s1_go, out_valid_r)

endmodule
`default_nettype wire
